FILE: design/hhdc_pkg.sv
// Package for the heading-hold drive controller.
// Holds register indexes, beat layout widths, stage payload types and fixed constants.
// No dependencies.
package hhdc_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_HOLD_ENABLE      = 3'd0;
    localparam logic [2:0] REG_STICK_DEADBAND   = 3'd1;
    localparam logic [2:0] REG_GAIN_EIGHTHS     = 3'd2;
    localparam logic [2:0] REG_CORRECTION_LIMIT = 3'd3;
    localparam logic [2:0] REG_SETTLE_RATE      = 3'd4;

    localparam int CFG_DATA_W = 18;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 24;

    // reset values of the registers
    localparam logic        RST_HOLD_ENABLE      = 1'b1;
    localparam logic [6:0]  RST_STICK_DEADBAND   = 7'd5;
    localparam logic [7:0]  RST_GAIN_EIGHTHS     = 8'd16;
    localparam logic [6:0]  RST_CORRECTION_LIMIT = 7'd40;
    localparam logic [17:0] RST_SETTLE_RATE      = 18'd2000;

    // headings in centidegrees
    localparam logic [15:0]        FULL_TURN = 16'd36000;
    localparam logic signed [17:0] FULL_TURN_S = 18'sd36000;
    localparam logic signed [17:0] HALF_TURN_S = 18'sd18000;

    // x / 25 == (x * DIV25_MUL) >> DIV25_SHIFT for x < 2**18
    localparam logic [18:0] DIV25_MUL   = 19'd335545;
    localparam int          DIV25_SHIFT = 23;

    typedef struct packed {
        logic               drive;
        logic signed [7:0]  fwd;
        logic signed [7:0]  turn;
        logic               use_corr;
        logic               hold;
        logic signed [17:0] err;
    } s1_t;

    typedef struct packed {
        logic               drive;
        logic signed [7:0]  fwd;
        logic signed [7:0]  turn;
        logic               use_corr;
        logic               hold;
        logic               neg;
        logic [22:0]        prod;
    } s2_t;

endpackage

FILE: design/heading_hold_drive_controller_top.sv
// Heading-hold drive controller, top level.
// Uses hhdc_pkg for register indexes, constants and stage payload types.
//
// Usage:
//   s_axis carries one control tick per beat, m_axis returns one drive result per
//   beat. Configuration registers are written through cfg_we / cfg_index / cfg_data
//   while no tick is in flight; a write takes effect at the next clock edge.
//   Pipeline: input register, decision stage (heading latch update), error times
//   gain multiply, divide by 800 plus clamp into the output register. A tick
//   accepted into the input register moves through the s1, s2 and output
//   registers to m_axis. Throughput is one tick per cycle unless m_axis_tready
//   stalls the output. The latch state is read and written only in the decision
//   stage, so consecutive ticks update it in order with no bubble.
//   When m_axis_tready is low the stages fill up and hold; s_axis_tready drops
//   once every stage holds a beat, and each freed slot is refilled right away.
//   Reset (rst_n low, asynchronous) empties the pipeline, clears the heading latch
//   and loads the register defaults: hold on, deadband 5, gain 16/8, limit 40,
//   settle rate 2000 centidegrees per second.
module heading_hold_drive_controller_top
    import hhdc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // config write port
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // tick input
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [7:0] stick_forward, [15:8] stick_turn, [31:16] heading_now,
    // [50:32] yaw_rate, [51] heading_valid, [52] rate_valid, [53] sensor_ready,
    // [54] route_active, [55] zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // drive result
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [0] drive_valid, [8:1] forward_cmd, [16:9] turn_cmd, [17] hold_active,
    // [23:18] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // configuration
    logic        hold_enable_reg;
    logic [6:0]  stick_deadband_reg;
    logic [7:0]  gain_eighths_reg;
    logic [6:0]  correction_limit_reg;
    logic [17:0] settle_rate_reg;

    // heading latch
    logic        latched_reg, latched_next;
    logic [15:0] held_heading_reg, held_heading_next;

    // pipeline
    logic                 in_v_reg;
    logic [IN_DATA_W-1:0] in_data_reg;
    logic                 s1_v_reg;
    s1_t                  s1_reg, s1_next;
    logic                 s2_v_reg;
    s2_t                  s2_reg, s2_next;
    logic                 out_v_reg;
    logic [17:0]          out_reg, out_next;

    logic adv_out, adv_s2, adv_s1, adv_in;
    logic step_s1;

    assign adv_out = !out_v_reg || m_axis_tready;
    assign adv_s2  = !s2_v_reg || adv_out;
    assign adv_s1  = !s1_v_reg || adv_s2;
    assign adv_in  = !in_v_reg || adv_s1;
    assign step_s1 = in_v_reg && adv_s1;

    assign s_axis_tready = adv_in;
    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W-18){1'b0}}, out_reg};

    function automatic logic signed [7:0] deadband(input logic signed [7:0] v,
                                                   input logic [6:0] db);
        logic [7:0] mag;
        begin
            mag = v[7] ? 8'(-v) : 8'(v);
            deadband = (mag < {1'b0, db}) ? 8'sd0 : v;
        end
    endfunction

    // ---------------- decision stage ----------------
    logic signed [7:0]  fwd_db, turn_db;
    logic [15:0]        head_raw, head_now;
    logic signed [18:0] rate;
    logic [18:0]        rate_mag;
    logic               hvalid, rvalid, ready, route;
    logic               hold_cond, latch_now, latched_new;
    logic [15:0]        held_use;
    logic signed [17:0] diff, err;

    always_comb
    begin
        fwd_db   = deadband(in_data_reg[7:0], stick_deadband_reg);
        turn_db  = deadband(in_data_reg[15:8], stick_deadband_reg);
        head_raw = in_data_reg[31:16];
        head_now = (head_raw >= FULL_TURN) ? 16'(head_raw - FULL_TURN) : head_raw;
        rate     = in_data_reg[50:32];
        rate_mag = rate[18] ? 19'(-rate) : 19'(rate);
        hvalid   = in_data_reg[51];
        rvalid   = in_data_reg[52];
        ready    = in_data_reg[53];
        route    = in_data_reg[54];

        hold_cond = hold_enable_reg && ready && hvalid && (turn_db == 8'sd0)
                    && (fwd_db != 8'sd0);
        latch_now = !latched_reg && rvalid && (rate_mag < {1'b0, settle_rate_reg});
        latched_new = !route && hold_cond && (latched_reg || latch_now);
        held_use  = (!route && hold_cond && latch_now) ? head_now : held_heading_reg;

        // shortest wrapped error in [-18000, 17999]
        diff = $signed({2'b00, held_use}) - $signed({2'b00, head_now});
        if (diff >= HALF_TURN_S)
        begin
            err = diff - FULL_TURN_S;
        end
        else if (diff < -HALF_TURN_S)
        begin
            err = diff + FULL_TURN_S;
        end
        else
        begin
            err = diff;
        end

        s1_next.drive    = !route;
        s1_next.fwd      = route ? 8'sd0 : fwd_db;
        s1_next.turn     = route ? 8'sd0 : turn_db;
        s1_next.use_corr = latched_new;
        s1_next.hold     = latched_new;
        s1_next.err      = err;

        latched_next      = step_s1 ? latched_new : latched_reg;
        held_heading_next = step_s1 ? held_use : held_heading_reg;
    end

    // ---------------- multiply stage ----------------
    logic [14:0] err_mag;

    always_comb
    begin
        err_mag = s1_reg.err[17] ? 15'(-s1_reg.err) : 15'(s1_reg.err);
        s2_next.drive    = s1_reg.drive;
        s2_next.fwd      = s1_reg.fwd;
        s2_next.turn     = s1_reg.turn;
        s2_next.use_corr = s1_reg.use_corr;
        s2_next.hold     = s1_reg.hold;
        s2_next.neg      = s1_reg.err[17];
        s2_next.prod     = 23'(err_mag) * 23'(gain_eighths_reg);
    end

    // ---------------- divide by 800, clamp ----------------
    logic [17:0]       div_in;
    logic [36:0]       div_prod;
    logic [13:0]       quot;
    logic [6:0]        cmag;
    logic signed [7:0] corr, turn_out;

    always_comb
    begin
        // /800 == (>>5) then /25, truncating on the magnitude
        div_in   = s2_reg.prod[22:5];
        div_prod = 37'(div_in) * 37'(DIV25_MUL);
        quot     = div_prod[DIV25_SHIFT +: 14];
        cmag     = (quot > {7'd0, correction_limit_reg}) ? correction_limit_reg : quot[6:0];
        corr     = s2_reg.neg ? 8'(-$signed({1'b0, cmag})) : $signed({1'b0, cmag});
        turn_out = s2_reg.use_corr ? corr : s2_reg.turn;
        out_next = {s2_reg.hold, turn_out, s2_reg.fwd, s2_reg.drive};
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_enable_reg      <= RST_HOLD_ENABLE;
            stick_deadband_reg   <= RST_STICK_DEADBAND;
            gain_eighths_reg     <= RST_GAIN_EIGHTHS;
            correction_limit_reg <= RST_CORRECTION_LIMIT;
            settle_rate_reg      <= RST_SETTLE_RATE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_HOLD_ENABLE:      hold_enable_reg      <= cfg_data[0];
                REG_STICK_DEADBAND:   stick_deadband_reg   <= cfg_data[6:0];
                REG_GAIN_EIGHTHS:     gain_eighths_reg     <= cfg_data[7:0];
                REG_CORRECTION_LIMIT: correction_limit_reg <= cfg_data[6:0];
                REG_SETTLE_RATE:      settle_rate_reg      <= cfg_data[17:0];
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latched_reg      <= 1'b0;
            held_heading_reg <= 16'd0;
            in_v_reg         <= 1'b0;
            s1_v_reg         <= 1'b0;
            s2_v_reg         <= 1'b0;
            out_v_reg        <= 1'b0;
        end
        else
        begin
            latched_reg      <= latched_next;
            held_heading_reg <= held_heading_next;
            if (adv_in)
            begin
                in_v_reg <= s_axis_tvalid;
            end
            if (adv_s1)
            begin
                s1_v_reg <= in_v_reg;
            end
            if (adv_s2)
            begin
                s2_v_reg <= s1_v_reg;
            end
            if (adv_out)
            begin
                out_v_reg <= s2_v_reg;
            end
        end
    end

    // payload stages, no reset
    always_ff @(posedge clk)
    begin
        if (adv_in && s_axis_tvalid)
        begin
            in_data_reg <= s_axis_tdata;
        end
        if (step_s1)
        begin
            s1_reg <= s1_next;
        end
        if (adv_s2 && s1_v_reg)
        begin
            s2_reg <= s2_next;
        end
        if (adv_out && s2_v_reg)
        begin
            out_reg <= out_next;
        end
    end

    // ---------------- assertions ----------------
    // a held heading always comes with a drive command
    a_hold_implies_drive: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg && out_reg[17] |-> out_reg[0])
        else $error("hold_active without drive_valid");

    // a route tick yields an all-zero result
    a_route_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg && !out_reg[0] |-> out_reg == 18'd0)
        else $error("route result not zero");

    // a route tick clears the latch
    a_route_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step_s1 && in_data_reg[54] |=> !latched_reg)
        else $error("latch survived a route tick");

    // while holding, the turn command stays inside the correction limit
    a_corr_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg && out_reg[17] |->
            ($signed(out_reg[16:9]) <= $signed({1'b0, correction_limit_reg}))
            && ($signed(out_reg[16:9]) >= -$signed({1'b0, correction_limit_reg})))
        else $error("correction outside limit");

    // the latch moves only when a tick passes the decision stage
    a_latch_step: assert property (@(posedge clk) disable iff (!rst_n)
        !step_s1 |=> $stable(latched_reg) && $stable(held_heading_reg))
        else $error("latch changed without a tick");

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for heading_hold_drive_controller_top.
// Drives control ticks in random bursts against a stalling receiver and compares each drive
// result with an in-bench predictor of the heading latch. Depends on hhdc_pkg and the RTL.
module tb_top
    import hhdc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CDEG_FULL      = 36000;
    localparam int CDEG_HALF      = 18000;
    localparam int CDEG_WRAP_BIAS = 54000;
    localparam int GAIN_DIVISOR   = 800;
    localparam int SETTLE_MAX     = 262143;

    // members listed from the top bit down, so the struct packs straight onto tdata
    typedef struct packed {
        logic               route;
        logic               ready;
        logic               rvalid;
        logic               hvalid;
        logic signed [18:0] yaw;
        logic [15:0]        heading;
        logic signed [7:0]  turn;
        logic signed [7:0]  fwd;
    } tick_t;

    typedef struct packed {
        logic              hold;
        logic signed [7:0] turn;
        logic signed [7:0] fwd;
        logic              drive;
    } drive_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [2:0]            cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    heading_hold_drive_controller_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // predictor copy of the registers and the heading latch
    int cfg_hold_en  = RST_HOLD_ENABLE;
    int cfg_deadband = RST_STICK_DEADBAND;
    int cfg_gain     = RST_GAIN_EIGHTHS;
    int cfg_limit    = RST_CORRECTION_LIMIT;
    int cfg_settle   = RST_SETTLE_RATE;
    bit hold_latched = 1'b0;
    int latch_cdeg   = 0;

    drive_t drive_q[$];
    int     mismatches = 0;
    int     burst_left = 0;
    int     stall_left = 0;
    int     stall_mode = 0;

    function automatic int apply_deadband(logic signed [7:0] v);
        int val;
        int mag;
        val = int'(v);
        mag = (val < 0) ? -val : val;
        return (mag < cfg_deadband) ? 0 : val;
    endfunction

    function automatic drive_t predict_drive(tick_t t);
        drive_t r;
        int fwd;
        int turn;
        int now;
        int rate;
        int mag;
        int err;
        int corr;
        fwd  = apply_deadband(t.fwd);
        turn = apply_deadband(t.turn);
        now  = int'(t.heading) % CDEG_FULL;
        rate = int'(t.yaw);
        r    = '0;
        if (t.route)
        begin
            hold_latched = 1'b0;
            return r;
        end
        if (cfg_hold_en != 0 && t.ready && t.hvalid && turn == 0 && fwd != 0)
        begin
            mag = (rate < 0) ? -rate : rate;
            // rate validity only gates a new latch
            if (!hold_latched && t.rvalid && mag < cfg_settle)
            begin
                latch_cdeg   = now;
                hold_latched = 1'b1;
            end
            if (hold_latched)
            begin
                err  = ((latch_cdeg - now + CDEG_WRAP_BIAS) % CDEG_FULL) - CDEG_HALF;
                corr = err * cfg_gain / GAIN_DIVISOR;
                if (corr > cfg_limit)
                    corr = cfg_limit;
                if (corr < -cfg_limit)
                    corr = -cfg_limit;
                turn = corr;
            end
        end
        else
            hold_latched = 1'b0;
        r.drive = 1'b1;
        r.fwd   = fwd[7:0];
        r.turn  = turn[7:0];
        r.hold  = hold_latched;
        return r;
    endfunction

    function automatic tick_t mk_tick(int fwd, int turn, int heading, int yaw,
                                      bit hvalid, bit rvalid, bit ready, bit route);
        tick_t t;
        t.fwd     = 8'(fwd);
        t.turn    = 8'(turn);
        t.heading = 16'(heading);
        t.yaw     = 19'(yaw);
        t.hvalid  = hvalid;
        t.rvalid  = rvalid;
        t.ready   = ready;
        t.route   = route;
        return t;
    endfunction

    function automatic int pick_value(int lo, int hi);
        case ($urandom_range(0, 3))
            0: return lo;
            1: return hi;
            default: return $urandom_range(lo, hi);
        endcase
    endfunction

    task automatic flag_error(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    // one tick per call; the tick is predicted at the edge that accepts it
    task automatic send_tick(tick_t t);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, t};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        drive_q.push_back(predict_drive(t));
        if (burst_left > 0)
            burst_left--;
        else
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(0, 15);
        end
    endtask

    // wait for every outstanding result, then let the pipeline empty
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (drive_q.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, int val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_HOLD_ENABLE:      cfg_hold_en  = val & 'h1;
            REG_STICK_DEADBAND:   cfg_deadband = val & 'h7F;
            REG_GAIN_EIGHTHS:     cfg_gain     = val & 'hFF;
            REG_CORRECTION_LIMIT: cfg_limit    = val & 'h7F;
            REG_SETTLE_RATE:      cfg_settle   = val & 'h3FFFF;
            default: ;
        endcase
    endtask

    task automatic set_config(int hold_en, int deadband, int gain, int limit, int settle);
        drain();
        write_reg(REG_HOLD_ENABLE, hold_en);
        write_reg(REG_STICK_DEADBAND, deadband);
        write_reg(REG_GAIN_EIGHTHS, gain);
        write_reg(REG_CORRECTION_LIMIT, limit);
        write_reg(REG_SETTLE_RATE, settle);
    endtask

    task automatic test_stick_deadband();
        send_tick(mk_tick(0, 0, 0, 0, 1, 1, 1, 0));
        send_tick(mk_tick(4, -4, 1200, 0, 1, 1, 1, 0));
        // -128 has magnitude 128 and always clears the deadband
        send_tick(mk_tick(-128, 127, 100, 0, 1, 1, 1, 0));
        send_tick(mk_tick(127, -5, 100, 0, 1, 1, 1, 0));
        set_config(1, 127, 16, 40, 2000);
        send_tick(mk_tick(-127, -128, 500, 0, 1, 1, 1, 0));
        send_tick(mk_tick(126, 126, 500, 0, 1, 1, 1, 0));
        set_config(1, 0, 16, 40, 2000);
        send_tick(mk_tick(1, 0, 700, 0, 1, 1, 1, 0));
    endtask

    task automatic test_heading_latch();
        set_config(RST_HOLD_ENABLE, RST_STICK_DEADBAND, RST_GAIN_EIGHTHS,
                   RST_CORRECTION_LIMIT, RST_SETTLE_RATE);
        send_tick(mk_tick(100, 0, 0, 1999, 1, 1, 1, 0));
        // wrap across zero, then clamp both ways and the half-turn error
        send_tick(mk_tick(100, 2, 35999, 0, 1, 1, 1, 0));
        send_tick(mk_tick(100, 0, 30000, 0, 1, 1, 1, 0));
        send_tick(mk_tick(100, 0, 18000, 0, 1, 1, 1, 0));
        // heading above a full turn folds back first
        send_tick(mk_tick(100, 0, 65535, 0, 1, 1, 1, 0));
        // a bad rate reading keeps an existing latch correcting
        send_tick(mk_tick(100, 0, 35000, -200000, 1, 0, 1, 0));
        send_tick(mk_tick(100, 0, 35000, 0, 0, 1, 1, 0));
        send_tick(mk_tick(100, 0, 9000, 0, 1, 0, 1, 0));
        send_tick(mk_tick(100, 0, 9000, 2000, 1, 1, 1, 0));
        send_tick(mk_tick(100, 0, 9000, -1999, 1, 1, 1, 0));
        send_tick(mk_tick(100, 0, 9500, 0, 1, 1, 0, 0));
    endtask

    task automatic test_route_override();
        send_tick(mk_tick(-60, 0, 500, 0, 1, 1, 1, 0));
        send_tick(mk_tick(-60, 0, 500, 0, 1, 1, 1, 1));
        send_tick(mk_tick(-60, 0, 1500, 0, 1, 1, 1, 0));
    endtask

    task automatic test_gain_limit_extremes();
        set_config(1, 5, 255, 127, SETTLE_MAX);
        send_tick(mk_tick(90, 0, 0, -262144, 1, 1, 1, 0));
        send_tick(mk_tick(90, 0, 0, 262143, 1, 1, 1, 0));
        send_tick(mk_tick(90, 0, 0, 200000, 1, 1, 1, 0));
        send_tick(mk_tick(90, 0, 17999, 0, 1, 1, 1, 0));
        send_tick(mk_tick(90, 0, 100, 0, 1, 1, 1, 0));
        set_config(1, 5, 0, 127, 0);
        send_tick(mk_tick(90, 0, 100, 0, 1, 1, 1, 0));
        set_config(0, 5, 255, 0, 200000);
        send_tick(mk_tick(90, 0, 100, 0, 1, 1, 1, 0));
    endtask

    // mostly well-formed hold attempts: heading drifts, turn inside the deadband
    task automatic send_hold_run(int n, ref int base);
        tick_t t;
        int    mag;
        int    delta;
        for (int k = 0; k < n; k++)
        begin
            t        = '0;
            t.ready  = 1'b1;
            t.hvalid = 1'b1;
            t.rvalid = ($urandom_range(0, 9) != 0);
            mag      = (cfg_deadband > 1) ? $urandom_range(0, cfg_deadband - 1) : 0;
            t.turn   = $urandom_range(0, 1) ? 8'(-mag) : 8'(mag);
            mag      = $urandom_range((cfg_deadband > 1) ? cfg_deadband : 1, 127);
            t.fwd    = $urandom_range(0, 1) ? 8'(-mag) : 8'(mag);
            if ($urandom_range(0, 19) == 0)
                t.fwd = 8'sh80;
            if (cfg_settle > 0 && $urandom_range(0, 5) != 0)
                mag = $urandom_range(0, cfg_settle - 1);
            else
                mag = $urandom_range(0, SETTLE_MAX);
            t.yaw = $urandom_range(0, 1) ? 19'(-mag) : 19'(mag);
            delta = $urandom_range(0, 800);
            delta -= 400;
            if ($urandom_range(0, 9) == 0)
                delta = $urandom_range(0, CDEG_FULL - 1);
            base      = (base + delta + CDEG_FULL) % CDEG_FULL;
            t.heading = 16'(base);
            if ($urandom_range(0, 15) == 0)
                t.heading = 16'($urandom_range(CDEG_FULL, 65535));
            // break the run now and then
            case ($urandom_range(0, 23))
                0: t.turn   = 8'($urandom());
                1: t.hvalid = 1'b0;
                2: t.ready  = 1'b0;
                3: t.route  = 1'b1;
                default: ;
            endcase
            send_tick(t);
        end
    endtask

    task automatic test_random_ticks();
        int          sent;
        int          n;
        int          base;
        logic [63:0] rnd_bits;
        tick_t       t;
        for (int phase = 0; phase < 13; phase++)
        begin
            set_config(($urandom_range(0, 3) != 0) ? 1 : 0, pick_value(0, 127),
                       pick_value(0, 255), pick_value(0, 127),
                       ($urandom_range(0, 7) == 0) ? SETTLE_MAX : pick_value(0, 200000));
            sent = 0;
            base = $urandom_range(0, CDEG_FULL - 1);
            while (sent < 50)
            begin
                if ($urandom_range(0, 3) != 0)
                begin
                    n = $urandom_range(4, 20);
                    send_hold_run(n, base);
                end
                else
                begin
                    n = $urandom_range(1, 5);
                    for (int k = 0; k < n; k++)
                    begin
                        rnd_bits = {$urandom(), $urandom()};
                        t        = rnd_bits[$bits(tick_t)-1:0];
                        send_tick(t);
                    end
                end
                sent += n;
            end
        end
    endtask

    // receiver: alternate between always ready, random stalls and a fixed pattern
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 300);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= (stall_left % 3 != 0);
        endcase
    end

    always @(posedge clk)
    begin : check_results
        drive_t got;
        drive_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[17:0];
            if (drive_q.size() == 0)
                flag_error($sformatf("result with nothing outstanding: %h", m_axis_tdata));
            else
            begin
                want = drive_q.pop_front();
                if (got.drive !== want.drive || got.fwd !== want.fwd ||
                    got.turn !== want.turn || got.hold !== want.hold)
                    flag_error($sformatf(
                        "expected drive/fwd/turn/hold %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                        want.drive, want.fwd, want.turn, want.hold,
                        got.drive, got.fwd, got.turn, got.hold));
            end
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_stick_deadband();
        test_heading_latch();
        test_route_override();
        test_gain_limit_extremes();
        test_random_ticks();
        drain();
        if (mismatches == 0 && drive_q.size() == 0)
            $display("heading_hold_drive_controller_top verification clean");
        else
            $display("heading_hold_drive_controller_top verification failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("heading_hold_drive_controller_top verification failed");
        $finish;
    end
endmodule

FILE: sim.f
design/hhdc_pkg.sv
design/heading_hold_drive_controller_top.sv
tb/sv/tb_top.sv
